>>> rtl/sps_pkg.sv
// Shared types and constants for the stepper phase sequencer with serial output.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sps_pkg;

  localparam int unsigned NumMotorsDef = 6;
  localparam int unsigned ShiftWidth   = 8;
  localparam int unsigned PatternCount = 4;
  localparam int unsigned PhaseW       = 2;
  localparam int unsigned NibbleW      = 4;
  localparam int unsigned MotorIdW     = 3;
  localparam int unsigned ChainIdW     = 2;
  localparam int unsigned BitCntW      = $clog2(ShiftWidth);
  localparam int unsigned FifoDepth    = 2;
  localparam int unsigned ApbAddrW     = 4;
  localparam int unsigned ApbDataW     = 32;
  localparam int unsigned StreamW      = 8;

  typedef logic [NibbleW-1:0] nibble_t;
  typedef nibble_t [PatternCount-1:0] pattern_tbl_t;

  // One byte waiting to be shifted out on one chain.
  typedef struct packed {
    logic [ChainIdW-1:0]   chain_id;
    logic [ShiftWidth-1:0] shift_byte;
  } job_t;

  typedef enum logic [1:0] {
    REG_STEP_ZERO  = 2'd0,
    REG_STEP_ONE   = 2'd1,
    REG_STEP_TWO   = 2'd2,
    REG_STEP_THREE = 2'd3
  } reg_idx_e;

  // Full-step pattern after reset: 9, 12, 6, 3 for phases 0 to 3.
  localparam pattern_tbl_t PatternReset = {4'd3, 4'd6, 4'd12, 4'd9};

endpackage

`default_nettype wire

>>> rtl/sps_front.sv
// Front end: accepts step requests, keeps per-motor phase and coil nibbles,
// and forms the pair byte for the queue. Depends on sps_pkg.
`default_nettype none

module sps_front #(
  parameter int unsigned NumMotors = sps_pkg::NumMotorsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [sps_pkg::MotorIdW-1:0] motor_sel_i,
  input  wire sps_pkg::pattern_tbl_t       pattern_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output sps_pkg::job_t                    job_o
);
  import sps_pkg::*;

  localparam int unsigned NumPairs = (NumMotors + 1) / 2;
  localparam int unsigned MotorW   = (NumMotors > 1) ? $clog2(NumMotors) : 1;
  localparam int unsigned PairW    = (NumPairs > 1) ? $clog2(NumPairs) : 1;

  logic [PhaseW-1:0] phase_q [NumMotors];
  nibble_t           lo_q    [NumPairs];
  nibble_t           hi_q    [NumPairs];

  logic              accept;
  logic              id_ok;
  logic              step;
  logic              is_odd;
  logic [MotorW-1:0] motor_idx;
  logic [PairW-1:0]  pair_idx;
  logic [PhaseW-1:0] new_phase;
  nibble_t           new_nib;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign id_ok      = 32'(motor_sel_i) < NumMotors;
  assign step       = accept && id_ok;
  assign is_odd     = motor_sel_i[0];
  assign motor_idx  = MotorW'(motor_sel_i);
  assign pair_idx   = PairW'(motor_sel_i[MotorIdW-1:1]);

  // The phase wraps from 3 to 0 by plain 2-bit overflow.
  assign new_phase  = phase_q[motor_idx] + 1'b1;
  assign new_nib    = pattern_i[new_phase];

  assign push_o = step;

  always_comb begin
    job_o.chain_id = motor_sel_i[MotorIdW-1:1];
    if (is_odd) begin
      job_o.shift_byte = {new_nib, lo_q[pair_idx]};
    end else begin
      job_o.shift_byte = {hi_q[pair_idx], new_nib};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMotors; i++) begin
        phase_q[i] <= '0;
      end
      for (int i = 0; i < NumPairs; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else if (step) begin
      phase_q[motor_idx] <= new_phase;
      if (is_odd) begin
        hi_q[pair_idx] <= new_nib;
      end else begin
        lo_q[pair_idx] <= new_nib;
      end
    end
  end

  // A stepped motor holds the advanced phase on the following cycle.
  a_phase_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> phase_q[$past(motor_idx)] == $past(new_phase))
    else $error("motor phase did not advance after a step");

endmodule

`default_nettype wire

>>> rtl/sps_fifo.sv
// Short queue of pending pair bytes between the front end and the serialiser.
// Depends on sps_pkg.
`default_nettype none

module sps_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sps_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output sps_pkg::job_t      job_o
);
  import sps_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  job_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(FifoDepth);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");

endmodule

`default_nettype wire

>>> rtl/sps_back.sv
// Back end: serialises one queued pair byte MSB first, one bit per item,
// and flags the final bit for the storage latch. Depends on sps_pkg.
`default_nettype none

module sps_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  wire sps_pkg::job_t                q_job_i,
  output logic                              pop_o,
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic [sps_pkg::ChainIdW-1:0]      chain_id_o,
  output logic                              data_bit_o,
  output logic                              latch_after_o
);
  import sps_pkg::*;

  logic                  busy_q;
  logic [BitCntW-1:0]    cnt_q;
  logic [ShiftWidth-1:0] shift_q;
  logic [ChainIdW-1:0]   chain_q;

  logic                  last;
  logic                  take;
  logic                  load;

  assign last = cnt_q == BitCntW'(ShiftWidth - 1);
  assign take = busy_q && m_tready_i;
  // A new byte loads when idle or straight after the final bit is taken.
  assign load = q_valid_i && (!busy_q || (take && last));

  assign pop_o         = load;
  assign m_tvalid_o    = busy_q;
  assign chain_id_o    = chain_q;
  assign data_bit_o    = shift_q[ShiftWidth-1];
  assign latch_after_o = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (take) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      shift_q <= q_job_i.shift_byte;
      chain_q <= q_job_i.chain_id;
    end else if (take) begin
      shift_q <= {shift_q[ShiftWidth-2:0], 1'b0};
    end
  end

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last && !q_valid_i |=> !busy_q)
    else $error("serialiser still busy after final bit with nothing queued");

endmodule

`default_nettype wire

>>> rtl/stepper_phase_shift_out_core.sv
// Top level of the stepper phase sequencer with serial shift-register output.
// Depends on sps_pkg, sps_front, sps_fifo and sps_back.
`default_nettype none

// Each item on the input stream names one motor (tdata bits 2..0). The motor's
// phase advances by one, its coil nibble is reloaded from the four-entry
// pattern table, and the byte of its pair (odd motor high, even motor low) is
// sent MSB first as eight output items on chain motor number / 2; the eighth
// item carries tlast, the latch pulse. Motor ids of NumMotors or above are
// accepted and dropped without output. The serialiser shifts out one bit per
// cycle while m_tready is high; the front end and a two-entry queue
// accept further items while a byte is still being shifted, so input stalls
// only when the queue is full. The pattern table is written through the
// APB-style port at byte addresses 0, 4, 8 and 12 and should only be changed
// while the block is idle.
module stepper_phase_shift_out_core #(
  parameter int unsigned NumMotors = sps_pkg::NumMotorsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input stream.
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  input  wire logic [sps_pkg::StreamW-1:0]  s_tdata_i,   // [2:0] motor_sel, rest unused
  // Output stream.
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic [sps_pkg::StreamW-1:0]       m_tdata_o,   // [0] data_bit, [7:1] zero
  output logic [sps_pkg::ChainIdW-1:0]      m_tuser_o,   // [1:0] chain_id
  output logic                              m_tlast_o,   // latch_after
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sps_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [sps_pkg::ApbDataW-1:0] pwdata,
  output logic [sps_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);
  import sps_pkg::*;

  pattern_tbl_t pattern_q;
  reg_idx_e     reg_idx;
  logic         cfg_write;

  logic         push;
  logic         q_full;
  job_t         push_job;
  logic         q_valid;
  job_t         q_job;
  logic         pop;
  logic         data_bit;

  // Register file: the pattern table, one nibble per word.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_STEP_ZERO:  prdata = ApbDataW'(pattern_q[0]);
      REG_STEP_ONE:   prdata = ApbDataW'(pattern_q[1]);
      REG_STEP_TWO:   prdata = ApbDataW'(pattern_q[2]);
      REG_STEP_THREE: prdata = ApbDataW'(pattern_q[3]);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PatternReset;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_STEP_ZERO:  pattern_q[0] <= pwdata[NibbleW-1:0];
        REG_STEP_ONE:   pattern_q[1] <= pwdata[NibbleW-1:0];
        REG_STEP_TWO:   pattern_q[2] <= pwdata[NibbleW-1:0];
        REG_STEP_THREE: pattern_q[3] <= pwdata[NibbleW-1:0];
        default:        pattern_q    <= pattern_q;
      endcase
    end
  end

  sps_front #(
    .NumMotors (NumMotors)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .motor_sel_i (s_tdata_i[MotorIdW-1:0]),
    .pattern_i   (pattern_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  sps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  sps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_job_i       (q_job),
    .pop_o         (pop),
    .m_tvalid_o    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .chain_id_o    (m_tuser_o),
    .data_bit_o    (data_bit),
    .latch_after_o (m_tlast_o)
  );

  assign m_tdata_o = StreamW'(data_bit);

endmodule

`default_nettype wire
